[hdl/int_to_ascii_radix_assert.svh]
// Assertion macros shared by the int_to_ascii_radix checkers.
// Depends on nothing; included by hdl/itar_checker.sv.
`ifndef INT_TO_ASCII_RADIX_ASSERT_SVH
`define INT_TO_ASCII_RADIX_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define ITAR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ITAR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/itar_pkg.sv]
// Package for int_to_ascii_radix: character codes, radix limits, controller/datapath
// command and status structs, and the digit-to-character function. No dependencies.
package itar_pkg;

    // Widths and defaults
    localparam int unsigned WORD_BITS_DEF = 32;
    localparam int unsigned RADIX_W       = 6;
    localparam int unsigned CHAR_W        = 7;
    localparam int unsigned DIV_STEP      = 8;   // quotient bits resolved per cycle

    // Radix limits
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] DEC_RADIX   = 6'd10;
    localparam logic [RADIX_W-1:0] MAX_DEC_DIGIT = 6'd9;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // capture the input word and sign
        logic div_step;    // resolve DIV_STEP quotient bits
        logic push;        // push finished digit, clear remainder
        logic emit_sign;   // put '-' on the output register
        logic emit_digit;  // put top digit on the output register, pop
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic neg;         // current number gets a leading '-'
        logic quot_zero;   // quotient left in the word register is zero
        logic last_digit;  // one digit left on the stack
    } t_dp_status;

    // Digit value to lower-case ASCII
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = CHAR_W'(d);
        if (d > MAX_DEC_DIGIT) begin
            return CHAR_A + d_ext - CHAR_W'(DEC_RADIX);
        end
        return CHAR_ZERO + d_ext;
    endfunction

endpackage

[hdl/itar_datapath.sv]
// Datapath for int_to_ascii_radix: radix register, shift-subtract divider,
// digit stack and output register. Depends on itar_pkg.
module itar_datapath
    import itar_pkg::*;
#(
    parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [RADIX_W-1:0]   i_cfg_data,
    input  logic [WORD_BITS-1:0] i_value,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    output logic [CHAR_W-1:0]    o_char_code,
    output logic                 o_last_char
);

    localparam int unsigned STEPS    = (WORD_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int unsigned PAD_BITS = STEPS * DIV_STEP;
    localparam int unsigned CNT_W    = $clog2(WORD_BITS + 1);

    logic [RADIX_W-1:0]  r_radix;
    logic [RADIX_W-1:0]  n_radix;
    logic [PAD_BITS-1:0] r_word;
    logic [PAD_BITS-1:0] n_word;
    logic [RADIX_W-1:0]  r_rem;
    logic [RADIX_W-1:0]  n_rem;
    logic                r_neg;
    logic [CNT_W-1:0]    r_count;
    logic [RADIX_W-1:0]  r_stack [WORD_BITS];
    logic [CHAR_W-1:0]   r_char;
    logic                r_last;
    logic [WORD_BITS-1:0] in_word;
    logic [WORD_BITS-1:0] in_mag;
    logic                 in_neg;

    // Saturate the written radix into 2..36
    always_comb begin
        if (i_cfg_data < RADIX_MIN) begin
            n_radix = RADIX_MIN;
        end else if (i_cfg_data > RADIX_MAX) begin
            n_radix = RADIX_MAX;
        end else begin
            n_radix = i_cfg_data;
        end
    end

    // Sign only in base ten; magnitude of the most negative value wraps to 2^(N-1)
    assign in_word = i_value;
    assign in_neg  = (r_radix == DEC_RADIX) && in_word[WORD_BITS-1];
    assign in_mag  = in_neg ? (~in_word + 1'b1) : in_word;

    // Shift-subtract division, DIV_STEP quotient bits per cycle
    always_comb begin
        logic [RADIX_W:0] t;
        n_word = r_word;
        n_rem  = r_rem;
        for (int i = 0; i < DIV_STEP; i++) begin
            t      = {n_rem, n_word[PAD_BITS-1]};
            n_word = {n_word[PAD_BITS-2:0], 1'b0};
            if (t >= {1'b0, r_radix}) begin
                n_rem     = RADIX_W'(t - {1'b0, r_radix});
                n_word[0] = 1'b1;
            end else begin
                n_rem = t[RADIX_W-1:0];
            end
        end
    end

    // Control registers: radix, digit count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
            r_count <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_radix <= n_radix;
            end
            if (i_cmd.load) begin
                r_count <= '0;
            end else if (i_cmd.push) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.emit_digit) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Working word, remainder and sign
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word <= PAD_BITS'(in_mag);
            r_rem  <= '0;
            r_neg  <= in_neg;
        end else if (i_cmd.div_step) begin
            r_word <= n_word;
            r_rem  <= i_cmd.push ? '0 : n_rem;
        end
    end

    // Digit stack: push on digit done, pop on emit
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_stack[0] <= n_rem;
            for (int i = 1; i < WORD_BITS; i++) begin
                r_stack[i] <= r_stack[i-1];
            end
        end else if (i_cmd.emit_digit) begin
            for (int i = 0; i < WORD_BITS - 1; i++) begin
                r_stack[i] <= r_stack[i+1];
            end
        end
    end

    // Output character register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            r_char <= CHAR_MINUS;
            r_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_char <= digit_char(r_stack[0]);
            r_last <= o_status.last_digit;
        end
    end

    assign o_status.neg        = r_neg;
    assign o_status.quot_zero  = (r_word == '0);
    assign o_status.last_digit = (r_count == CNT_W'(1));
    assign o_char_code         = r_char;
    assign o_last_char         = r_last;

endmodule

[hdl/itar_ctrl.sv]
// Controller for int_to_ascii_radix: sequences load, divide, digit check and
// character emission. Depends on itar_pkg.
module itar_ctrl
    import itar_pkg::*;
#(
    parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_char_valid
);

    localparam int unsigned STEPS = (WORD_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int unsigned STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_CHECK,
        S_SIGN,
        S_EMIT
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic              n_char_valid;
    logic              r_char_valid;
    logic              step_last;

    assign step_last = (r_step == STEP_W'(STEPS - 1));

    // Next state and datapath commands
    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_char_valid = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (step_last) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_CHECK;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_CHECK: begin
                if (!i_status.quot_zero) begin
                    n_step  = '0;
                    n_state = S_DIV;
                end else if (i_status.neg) begin
                    n_state = S_SIGN;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_SIGN: begin
                o_cmd.emit_sign = 1'b1;
                n_char_valid    = 1'b1;
                n_state         = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit_digit = 1'b1;
                n_char_valid     = 1'b1;
                if (i_status.last_digit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, step counter and output strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_step       <= '0;
            r_char_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_step       <= n_step;
            r_char_valid <= n_char_valid;
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_char_valid = r_char_valid;

endmodule

[hdl/int_to_ascii_radix.sv]
// Top level of int_to_ascii_radix: integer to ASCII text in a configurable radix.
// Depends on itar_pkg, itar_ctrl and itar_datapath.
//
// Usage:
//   Input: a word on i_value is taken at a rising edge with start high and busy low.
//   Output: one character per cycle on o_char_code, marked by o_char_valid for
//   exactly one cycle, most significant character first; o_last_char flags the
//   final character. A leading '-' appears only for negative values in base ten.
//   Config: i_cfg_data (radix) is written when i_cfg_valid is high; o_cfg_ready is
//   always high. Values below 2 or above 36 saturate. Write only while idle.
// Timing:
//   Each digit takes STEPS steps in the shift-subtract divider, which
//   resolves 8 quotient bits per cycle (STEPS = ceil(WORD_BITS/8), 4 at 32 bits),
//   and then a test of the quotient. Characters then leave one per cycle. One item
//   is in flight; the next word is taken in the last character's cycle.
// Reset: synchronous, active low; radix returns to 10, any number in progress is
//   dropped. The receiver cannot stall: every strobed character must be taken.
module int_to_ascii_radix
    import itar_pkg::*;
#(
    parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [WORD_BITS-1:0] i_value,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [RADIX_W-1:0]          i_cfg_data,
    output logic                        o_char_valid,
    output logic [CHAR_W-1:0]           o_char_code,
    output logic                        o_last_char
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Radix register accepts a word every cycle
    assign o_cfg_ready = 1'b1;

    itar_ctrl #(
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_status     (dp_status),
        .o_cmd        (dp_cmd),
        .o_char_valid (o_char_valid)
    );

    itar_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid & o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_value     (i_value),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

endmodule

[hdl/itar_checker.sv]
// Port-level checker for int_to_ascii_radix and its bind statement.
// Depends on itar_pkg and int_to_ascii_radix_assert.svh.
`include "int_to_ascii_radix_assert.svh"

module itar_checker
    import itar_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_char_valid,
    input logic [CHAR_W-1:0] o_char_code,
    input logic              o_last_char
);

    // An accepted word starts the converter
    `ITAR_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy, "accepted word did not raise busy")

    // Only '-', digits and lower-case letters leave the block
    `ITAR_ASSERT_IMPLY(a_char_set, i_clk, i_rst_n, o_char_valid, (o_char_code == CHAR_MINUS) || ((o_char_code >= CHAR_ZERO) && (o_char_code <= (CHAR_ZERO + 7'd9))) || ((o_char_code >= CHAR_A) && (o_char_code <= (CHAR_A + 7'd25))), "character outside the digit set")

    // A sign is always followed by at least one digit
    `ITAR_ASSERT_IMPLY(a_sign_not_last, i_clk, i_rst_n, o_char_valid && (o_char_code == CHAR_MINUS), !o_last_char, "sign marked as last character")

    // While characters are still owed the block stays busy
    `ITAR_ASSERT_IMPLY(a_more_busy, i_clk, i_rst_n, o_char_valid && !o_last_char, busy, "idle before last character")

endmodule

bind int_to_ascii_radix itar_checker u_itar_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_char_valid (o_char_valid),
    .o_char_code  (o_char_code),
    .o_last_char  (o_last_char)
);
